### design/circle_pair_collision_response_core_macros.svh
// ----------------------------------------------------------------------------
// Circle pair collision response assertion macros
// Shared assertion forms for the collision response core.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CPCR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define CPCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// Circle pair collision response package
// Item types, context carried down the pipeline, constants and saturation.
// ----------------------------------------------------------------------------
package cpcr_pkg;

   localparam int FRACTION_BITS = 8;
   localparam int ZERO_DIST_RAW = ((3 << FRACTION_BITS) + 128) >> 8;
   localparam int ZERO_DIST     = (ZERO_DIST_RAW < 1) ? 1 : ZERO_DIST_RAW;

   localparam logic [8:0] RESTITUTION_RESET = 9'd205;
   localparam logic [1:0] ADDR_RESTITUTION  = 2'd0;

   typedef struct packed {
      logic signed [23:0] first_x;
      logic signed [23:0] first_y;
      logic signed [23:0] first_vx;
      logic signed [23:0] first_vy;
      logic        [15:0] first_radius;
      logic signed [23:0] second_x;
      logic signed [23:0] second_y;
      logic signed [23:0] second_vx;
      logic signed [23:0] second_vy;
      logic        [15:0] second_radius;
   } req_type;

   typedef struct packed {
      logic signed [23:0] new_first_x;
      logic signed [23:0] new_first_y;
      logic signed [23:0] new_first_vx;
      logic signed [23:0] new_first_vy;
      logic signed [23:0] new_second_x;
      logic signed [23:0] new_second_y;
      logic signed [23:0] new_second_vx;
      logic signed [23:0] new_second_vy;
      logic               collided;
   } rsp_type;

   // Per-item context; fields fill in as the item moves down the pipe.
   typedef struct packed {
      req_type            item;
      logic               hit;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [24:0] dvx;
      logic signed [24:0] dvy;
      logic        [16:0] rsum;
      logic        [17:0] span;
      logic               closing;
      logic signed [18:0] sxp;
      logic signed [18:0] syp;
   } ctx_type;

   function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
      logic signed [23:0] r;
      if (v > 32'sd8388607) begin
         r = 24'sh7fffff;
      end else if (v < -32'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

### design/cpcr_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor result, sideband travels with each item.
// ----------------------------------------------------------------------------
module cpcr_sqrt
   import cpcr_pkg::*;
#(
   parameter int IW = 36,
   parameter int SW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IW-1:0]     in_rad,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [IW/2-1:0]   out_root,
   output logic [SW-1:0]     out_side
);

   localparam int RTW  = IW / 2;
   localparam int REMW = RTW + 3;

   logic [IW-1:0]   rad_ff  [1:RTW];
   logic [REMW-1:0] rem_ff  [1:RTW];
   logic [RTW-1:0]  root_ff [1:RTW];
   logic [SW-1:0]   side_ff [1:RTW];
   logic            vld_ff  [1:RTW];

   for (genvar k = 1; k <= RTW; k++) begin : g_stage
      logic [IW-1:0]   rad_prev;
      logic [REMW-1:0] rem_prev;
      logic [RTW-1:0]  root_prev;
      logic [SW-1:0]   side_prev;
      logic            vld_prev;
      logic [REMW-1:0] cur;
      logic [REMW-1:0] trial;
      logic            take;

      if (k == 1) begin : g_first
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign cur   = {rem_prev[REMW-3:0], rad_prev[IW-1 -: 2]};
      assign trial = REMW'({root_prev, 2'b01});
      assign take  = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_prev << 2;
            rem_ff[k]  <= take ? (cur - trial) : cur;
            root_ff[k] <= {root_prev[RTW-2:0], take};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[RTW];
   assign out_root  = root_ff[RTW];
   assign out_side  = side_ff[RTW];

endmodule

### design/cpcr_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division, one quotient bit per stage, several lanes in lockstep;
// rounds to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module cpcr_div
   import cpcr_pkg::*;
#(
   parameter int LANES = 2,
   parameter int NW    = 44,
   parameter int DW    = 19,
   parameter int QW    = 28,
   parameter int SW    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     in_mag  [LANES],
   input  logic              in_neg  [LANES],
   input  logic [DW-1:0]     in_den  [LANES],
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic signed [QW:0] out_quo [LANES],
   output logic [SW-1:0]     out_side
);

   localparam int RW = ((NW + 1) > (DW + QW)) ? (NW + 1) : (DW + QW);

   logic [RW-1:0] rem_ff  [0:QW-1][LANES];
   logic [DW-1:0] den_ff  [0:QW-1][LANES];
   logic [QW-1:0] quo_ff  [1:QW][LANES];
   logic          neg_ff  [0:QW][LANES];
   logic [SW-1:0] side_ff [0:QW];
   logic          vld_ff  [0:QW];

   // Entry stage: add half the divisor for rounding.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_entry
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0][l] <= RW'(in_mag[l]) + RW'(in_den[l] >> 1);
            den_ff[0][l] <= in_den[l];
            neg_ff[0][l] <= in_neg[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      localparam int SH = QW - k;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [RW-1:0] dsh;
         logic [QW-1:0] qprev;
         logic          take;

         assign dsh  = RW'(den_ff[k-1][l]) << SH;
         assign take = (rem_ff[k-1][l] >= dsh);

         if (k == 1) begin : g_q0
            assign qprev = '0;
         end else begin : g_qn
            assign qprev = quo_ff[k-1][l];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               quo_ff[k][l] <= qprev | (take ? (QW'(1) << SH) : QW'(0));
               neg_ff[k][l] <= neg_ff[k-1][l];
            end
         end

         if (k < QW) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][l] <= take ? (rem_ff[k-1][l] - dsh) : rem_ff[k-1][l];
                  den_ff[k][l] <= den_ff[k-1][l];
               end
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quo[l] = neg_ff[QW][l] ? -$signed({1'b0, quo_ff[QW][l]})
                                        :  $signed({1'b0, quo_ff[QW][l]});
   end

   assign out_valid = vld_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

### design/circle_pair_collision_response_core.sv
// Throughput: one item per cycle; the whole pipe advances together and
//    holds while the output register is full and rsp_ready is low.
// Depth is set by the 18-stage square root and the two rounding dividers
//    (29 and 31 stages: an entry stage, then one quotient bit per stage).
// Reset clears all valid bits and loads restitution with 205.
// ----------------------------------------------------------------------------
// Circle pair collision response core
// Resolves overlap of two equal-mass circles: positional push-out along the
// normal and a restitution-scaled impulse when the circles are closing.
// ----------------------------------------------------------------------------
`include "circle_pair_collision_response_core_macros.svh"

module circle_pair_collision_response_core
   import cpcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CTXW = $bits(ctx_type);

   // ---------------------------------------------------------------------
   // Register port: restitution is the only register.
   // ---------------------------------------------------------------------
   logic [8:0] restitution_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_RESTITUTION);
   assign csr_prdata = (csr_paddr == ADDR_RESTITUTION) ? {23'd0, restitution_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= RESTITUTION_RESET;
      end else if (csr_write) begin
         restitution_ff <= csr_pwdata[8:0];
      end
   end

   // ---------------------------------------------------------------------
   // Global advance: every stage moves when the output slot frees up.
   // ---------------------------------------------------------------------
   logic    en;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Stage 1: capture the item.
   logic    s1_vld_ff;
   req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: differences, radius sum, coarse range check.
   // A difference of 2^17 or more can never be inside rsum, so drop it here
   // and keep the squares narrow.
   logic signed [24:0] dx_wide;
   logic signed [24:0] dy_wide;
   logic               near;
   ctx_type            s2_ctx_in;
   ctx_type            s2_ctx_ff;
   logic               s2_vld_ff;

   assign dx_wide = 25'(s1_req_ff.second_x) - 25'(s1_req_ff.first_x);
   assign dy_wide = 25'(s1_req_ff.second_y) - 25'(s1_req_ff.first_y);
   assign near    = (dx_wide > -25'sd131072) && (dx_wide < 25'sd131072)
                    && (dy_wide > -25'sd131072) && (dy_wide < 25'sd131072);

   always_comb begin
      s2_ctx_in      = '0;
      s2_ctx_in.item = s1_req_ff;
      s2_ctx_in.hit  = near;
      s2_ctx_in.dx   = dx_wide[17:0];
      s2_ctx_in.dy   = dy_wide[17:0];
      s2_ctx_in.dvx  = 25'(s1_req_ff.second_vx) - 25'(s1_req_ff.first_vx);
      s2_ctx_in.dvy  = 25'(s1_req_ff.second_vy) - 25'(s1_req_ff.first_vy);
      s2_ctx_in.rsum = 17'(s1_req_ff.first_radius) + 17'(s1_req_ff.second_radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ctx_ff <= s2_ctx_in;
      end
   end

   // Stage 3: squares.
   logic signed [35:0] sqx;
   logic signed [35:0] sqy;
   logic        [33:0] rsq_in;
   logic        [33:0] s3_dx2_ff;
   logic        [33:0] s3_dy2_ff;
   logic        [33:0] s3_rsq_ff;
   ctx_type            s3_ctx_ff;
   logic               s3_vld_ff;

   assign sqx    = 36'(s2_ctx_ff.dx) * 36'(s2_ctx_ff.dx);
   assign sqy    = 36'(s2_ctx_ff.dy) * 36'(s2_ctx_ff.dy);
   assign rsq_in = 34'(s2_ctx_ff.rsum) * 34'(s2_ctx_ff.rsum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_dx2_ff <= sqx[33:0];
         s3_dy2_ff <= sqy[33:0];
         s3_rsq_ff <= rsq_in;
         s3_ctx_ff <= s2_ctx_ff;
      end
   end

   // Stage 4: squared distance and the touch test.
   logic [34:0] d2_in;
   ctx_type     s4_ctx_in;
   ctx_type     s4_ctx_ff;
   logic [34:0] s4_d2_ff;
   logic        s4_vld_ff;

   assign d2_in = 35'(s3_dx2_ff) + 35'(s3_dy2_ff);

   always_comb begin
      s4_ctx_in     = s3_ctx_ff;
      s4_ctx_in.hit = s3_ctx_ff.hit && (d2_in < 35'(s3_rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_d2_ff  <= d2_in;
         s4_ctx_ff <= s4_ctx_in;
      end
   end

   // Square root of the squared distance.
   logic            sq_vld;
   logic [17:0]     sq_root;
   logic [CTXW-1:0] sq_side;
   ctx_type         sq_ctx;

   cpcr_sqrt #(
      .IW (36),
      .SW (CTXW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_rad    ({1'b0, s4_d2_ff}),
      .in_side   (s4_ctx_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign sq_ctx = ctx_type'(sq_side);

   // Stage 5: distance, overlap and the products for push and closing speed.
   // Coincident centres get a small nonzero distance.
   logic        [17:0] span;
   logic signed [18:0] overlap;
   ctx_type            s5_ctx_in;
   ctx_type            s5_ctx_ff;
   logic signed [36:0] s5_pnx_ff;
   logic signed [36:0] s5_pny_ff;
   logic signed [42:0] s5_numx_ff;
   logic signed [42:0] s5_numy_ff;
   logic               s5_vld_ff;

   assign span    = (sq_root == '0) ? 18'(ZERO_DIST) : sq_root;
   assign overlap = 19'(sq_ctx.rsum) - 19'(span);

   always_comb begin
      s5_ctx_in      = sq_ctx;
      s5_ctx_in.span = span;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ctx_ff  <= s5_ctx_in;
         s5_pnx_ff  <= 37'(sq_ctx.dx) * 37'(overlap);
         s5_pny_ff  <= 37'(sq_ctx.dy) * 37'(overlap);
         s5_numx_ff <= 43'(sq_ctx.dvx) * 43'(sq_ctx.dx);
         s5_numy_ff <= 43'(sq_ctx.dvy) * 43'(sq_ctx.dy);
      end
   end

   // Stage 6: closing speed numerator, sign and magnitude split for the
   // first divider (lanes: push x, push y, normal speed).
   logic signed [43:0] num;
   ctx_type            s6_ctx_in;
   ctx_type            s6_ctx_ff;
   logic        [43:0] s6_mag_ff [3];
   logic               s6_neg_ff [3];
   logic        [18:0] s6_den_ff [3];
   logic               s6_vld_ff;

   assign num = 44'(s5_numx_ff) + 44'(s5_numy_ff);

   always_comb begin
      s6_ctx_in         = s5_ctx_ff;
      s6_ctx_in.closing = (num <= 44'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ctx_ff    <= s6_ctx_in;
         s6_mag_ff[0] <= 44'(s5_pnx_ff[36] ? -s5_pnx_ff : s5_pnx_ff);
         s6_mag_ff[1] <= 44'(s5_pny_ff[36] ? -s5_pny_ff : s5_pny_ff);
         s6_mag_ff[2] <= num[43] ? -num : num;
         s6_neg_ff[0] <= s5_pnx_ff[36];
         s6_neg_ff[1] <= s5_pny_ff[36];
         s6_neg_ff[2] <= num[43];
         s6_den_ff[0] <= {s5_ctx_ff.span, 1'b0};
         s6_den_ff[1] <= {s5_ctx_ff.span, 1'b0};
         s6_den_ff[2] <= {1'b0, s5_ctx_ff.span};
      end
   end

   logic               da_vld;
   logic signed [28:0] da_quo [3];
   logic [CTXW-1:0]    da_side;
   ctx_type            da_ctx;

   cpcr_div #(
      .LANES (3),
      .NW    (44),
      .DW    (19),
      .QW    (28),
      .SW    (CTXW)
   ) u_div_push (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_vld_ff),
      .in_mag    (s6_mag_ff),
      .in_neg    (s6_neg_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_ctx_ff),
      .out_valid (da_vld),
      .out_quo   (da_quo),
      .out_side  (da_side)
   );

   assign da_ctx = ctx_type'(da_side);

   // Stage 7: keep the push, scale normal speed by the normal components.
   ctx_type            s7_ctx_in;
   ctx_type            s7_ctx_ff;
   logic signed [46:0] s7_vdx_ff;
   logic signed [46:0] s7_vdy_ff;
   logic               s7_vld_ff;

   always_comb begin
      s7_ctx_in     = da_ctx;
      s7_ctx_in.sxp = da_quo[0][18:0];
      s7_ctx_in.syp = da_quo[1][18:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= da_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ctx_ff <= s7_ctx_in;
         s7_vdx_ff <= 47'(da_quo[2]) * 47'(da_ctx.dx);
         s7_vdy_ff <= 47'(da_quo[2]) * 47'(da_ctx.dy);
      end
   end

   // Stage 8: apply (1 + restitution); the impulse opposes the normal
   // speed, so flip the sign going into the second divider.
   logic        [9:0]  kfac;
   logic signed [57:0] jx;
   logic signed [57:0] jy;
   logic signed [57:0] njx;
   logic signed [57:0] njy;
   ctx_type            s8_ctx_ff;
   logic        [56:0] s8_mag_ff [2];
   logic               s8_neg_ff [2];
   logic        [26:0] s8_den_ff [2];
   logic               s8_vld_ff;

   assign kfac = 10'd256 + 10'(restitution_ff);
   assign jx   = 58'(s7_vdx_ff) * $signed({48'd0, kfac});
   assign jy   = 58'(s7_vdy_ff) * $signed({48'd0, kfac});
   assign njx  = -jx;
   assign njy  = -jy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (en) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_ctx_ff    <= s7_ctx_ff;
         s8_mag_ff[0] <= jx[57] ? njx[56:0] : jx[56:0];
         s8_mag_ff[1] <= jy[57] ? njy[56:0] : jy[56:0];
         s8_neg_ff[0] <= !jx[57];
         s8_neg_ff[1] <= !jy[57];
         s8_den_ff[0] <= {s7_ctx_ff.span, 9'd0};
         s8_den_ff[1] <= {s7_ctx_ff.span, 9'd0};
      end
   end

   logic               db_vld;
   logic signed [30:0] db_quo [2];
   logic [CTXW-1:0]    db_side;
   ctx_type            db_ctx;

   cpcr_div #(
      .LANES (2),
      .NW    (57),
      .DW    (27),
      .QW    (30),
      .SW    (CTXW)
   ) u_div_impulse (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_vld_ff),
      .in_mag    (s8_mag_ff),
      .in_neg    (s8_neg_ff),
      .in_den    (s8_den_ff),
      .in_side   (s8_ctx_ff),
      .out_valid (db_vld),
      .out_quo   (db_quo),
      .out_side  (db_side)
   );

   assign db_ctx = ctx_type'(db_side);

   // Output stage: apply push and impulse, saturate, hold until taken.
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.new_first_x   = db_ctx.item.first_x;
      rsp_data_in.new_first_y   = db_ctx.item.first_y;
      rsp_data_in.new_first_vx  = db_ctx.item.first_vx;
      rsp_data_in.new_first_vy  = db_ctx.item.first_vy;
      rsp_data_in.new_second_x  = db_ctx.item.second_x;
      rsp_data_in.new_second_y  = db_ctx.item.second_y;
      rsp_data_in.new_second_vx = db_ctx.item.second_vx;
      rsp_data_in.new_second_vy = db_ctx.item.second_vy;
      rsp_data_in.collided      = db_ctx.hit;
      if (db_ctx.hit) begin
         rsp_data_in.new_first_x  = sat24(32'(db_ctx.item.first_x) - 32'(db_ctx.sxp));
         rsp_data_in.new_first_y  = sat24(32'(db_ctx.item.first_y) - 32'(db_ctx.syp));
         rsp_data_in.new_second_x = sat24(32'(db_ctx.item.second_x) + 32'(db_ctx.sxp));
         rsp_data_in.new_second_y = sat24(32'(db_ctx.item.second_y) + 32'(db_ctx.syp));
         if (db_ctx.closing) begin
            rsp_data_in.new_first_vx  = sat24(32'(db_ctx.item.first_vx) - 32'(db_quo[0]));
            rsp_data_in.new_first_vy  = sat24(32'(db_ctx.item.first_vy) - 32'(db_quo[1]));
            rsp_data_in.new_second_vx = sat24(32'(db_ctx.item.second_vx) + 32'(db_quo[0]));
            rsp_data_in.new_second_vy = sat24(32'(db_ctx.item.second_vy) + 32'(db_quo[1]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= db_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CPCR_ASSERT_NOW(a_root_inside_rsum, sq_vld && sq_ctx.hit, 18'(sq_ctx.rsum) > sq_root, "root not below radius sum for a touching pair")
   `CPCR_ASSERT_NEXT(a_csr_write, csr_write, restitution_ff == $past(csr_pwdata[8:0]), "restitution write lost")
   `CPCR_ASSERT_NOW(a_reset_value, $past(reset), restitution_ff == RESTITUTION_RESET, "restitution not at reset value")

endmodule

### sim/tb_circle_pair_collision_response_core.sv
// ----------------------------------------------------------------------------
// Circle pair collision response core testbench
// Streams circle pairs through the core and checks every result against an
// in-bench collision model: touch test, push-out, closing impulse and output
// saturation, over several restitution settings with random flow control.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_response_core
   import cpcr_pkg::*;
();

   localparam longint POS_MAX   = 64'sd8388607;
   localparam longint POS_MIN   = -64'sd8388608;
   localparam int     CYCLE_CAP = 600000;
   // Extra wait once every expected result is back.
   localparam int     PIPE_WAIT = 120;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   circle_pair_collision_response_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Model copy of the bounce register.
   logic [8:0] bounce_coef;

   rsp_type expected_pairs[$];
   int      mismatch_count;
   int      pairs_sent;
   int      pairs_checked;
   int      hits_seen;
   int      cycle_count;

   // Sender flow control: bursts of items with random gaps when enabled.
   bit      sender_gaps;
   int      burst_left;
   // Receiver flow control: stall pattern and a long hold-off request.
   bit      receiver_stalls;
   int      holdoff_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_pairs.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: a long hold-off wins, else stall on a random duty pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_stalls) begin
         rsp_ready <= (cycle_count % 23 < 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Collision model
   // ---------------------------------------------------------------------
   function automatic longint round_div(longint n, longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (m + (d >>> 1)) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return longint'(res);
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > POS_MAX) return 24'sh7fffff;
      if (v < POS_MIN) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic rsp_type resolve_pair(req_type p, logic [8:0] coef);
      rsp_type r;
      longint  x1, y1, vx1, vy1, x2, y2, vx2, vy2;
      longint  dx, dy, rsum, d2, span, overlap, push_x, push_y;
      longint  closing_rate, normal_vel, impulse, kick_x, kick_y;
      x1 = p.first_x;  y1 = p.first_y;  vx1 = p.first_vx;  vy1 = p.first_vy;
      x2 = p.second_x; y2 = p.second_y; vx2 = p.second_vx; vy2 = p.second_vy;
      dx = x2 - x1;
      dy = y2 - y1;
      rsum = longint'(p.first_radius) + longint'(p.second_radius);
      d2 = dx * dx + dy * dy;
      r.collided = 1'b0;
      if (d2 < rsum * rsum) begin
         r.collided = 1'b1;
         span = floor_sqrt(d2);
         // Coincident centres: fall back to a tiny fixed separation.
         if (span == 0) span = ZERO_DIST;
         overlap = rsum - span;
         push_x = round_div(dx * overlap, 2 * span);
         push_y = round_div(dy * overlap, 2 * span);
         closing_rate = (vx2 - vx1) * dx + (vy2 - vy1) * dy;
         x1 = x1 - push_x; y1 = y1 - push_y;
         x2 = x2 + push_x; y2 = y2 + push_y;
         if (closing_rate <= 0) begin
            normal_vel = round_div(closing_rate, span);
            impulse = -(256 + longint'(coef)) * normal_vel;
            kick_x = round_div(impulse * dx, span * 512);
            kick_y = round_div(impulse * dy, span * 512);
            vx1 = vx1 - kick_x; vy1 = vy1 - kick_y;
            vx2 = vx2 + kick_x; vy2 = vy2 + kick_y;
         end
      end
      r.new_first_x   = clamp24(x1);
      r.new_first_y   = clamp24(y1);
      r.new_first_vx  = clamp24(vx1);
      r.new_first_vy  = clamp24(vy1);
      r.new_second_x  = clamp24(x2);
      r.new_second_y  = clamp24(y2);
      r.new_second_vx = clamp24(vx2);
      r.new_second_vy = clamp24(vy2);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic bit field_ok(string name, longint want, longint got);
      if (want == got) return 1'b1;
      if (mismatch_count < 10) begin
         $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                  pairs_checked, name, want, got);
      end
      return 1'b0;
   endfunction

   // Sample at the falling edge; ready only moves at the rising edge.
   always @(negedge clock) begin
      rsp_type want;
      bit      good;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            if (mismatch_count < 10) $display("Result with nothing expected");
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_pairs.pop_front();
            good = 1'b1;
            good &= field_ok("new_first_x", want.new_first_x, rsp_data.new_first_x);
            good &= field_ok("new_first_y", want.new_first_y, rsp_data.new_first_y);
            good &= field_ok("new_first_vx", want.new_first_vx, rsp_data.new_first_vx);
            good &= field_ok("new_first_vy", want.new_first_vy, rsp_data.new_first_vy);
            good &= field_ok("new_second_x", want.new_second_x, rsp_data.new_second_x);
            good &= field_ok("new_second_y", want.new_second_y, rsp_data.new_second_y);
            good &= field_ok("new_second_vx", want.new_second_vx, rsp_data.new_second_vx);
            good &= field_ok("new_second_vy", want.new_second_vy, rsp_data.new_second_vy);
            good &= field_ok("collided", want.collided, rsp_data.collided);
            if (!good) mismatch_count = mismatch_count + 1;
            if (want.collided) hits_seen = hits_seen + 1;
            pairs_checked = pairs_checked + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Offer one item; return right after the edge that takes it, valid still high.
   task automatic send_pair(req_type p);
      bit took;
      if (sender_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      expected_pairs.insert(expected_pairs.size(), resolve_pair(p, bounce_coef));
      pairs_sent = pairs_sent + 1;
      if (burst_left > 0) burst_left = burst_left - 1;
   endtask

   // Drop valid and wait for the pipe to empty out.
   task automatic drain_all();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic write_bounce(logic [8:0] coef);
      drain_all();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_RESTITUTION;
      csr_pwdata  <= {23'd0, coef};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      bounce_coef = coef;
   endtask

   function automatic req_type make_pair(longint x1, longint y1, longint vx1,
                                         longint vy1, int r1, longint x2,
                                         longint y2, longint vx2, longint vy2,
                                         int r2);
      req_type p;
      p.first_x = x1[23:0];   p.first_y = y1[23:0];
      p.first_vx = vx1[23:0]; p.first_vy = vy1[23:0];
      p.first_radius = r1[15:0];
      p.second_x = x2[23:0];  p.second_y = y2[23:0];
      p.second_vx = vx2[23:0]; p.second_vy = vy2[23:0];
      p.second_radius = r2[15:0];
      return p;
   endfunction

   function automatic longint rand_full();
      return longint'($signed(24'($urandom)));
   endfunction

   // Place the second centre within reach; mirror the offset if it falls off.
   function automatic longint near_coord(longint base, longint offset);
      longint c;
      c = base + offset;
      if (c > POS_MAX || c < POS_MIN) c = base - offset;
      return c;
   endfunction

   function automatic req_type random_pair();
      req_type p;
      longint  x1, y1, reach;
      int      r1, r2, mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         // Noise: whole-range fields, almost never touching.
         p = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom});
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            r1 = $urandom_range(0, 65535);
            r2 = $urandom_range(0, 65535);
         end else begin
            r1 = $urandom_range(0, 4095);
            r2 = $urandom_range(0, 4095);
         end
         reach = r1 + r2 + 8;
         x1 = ($urandom_range(0, 3) == 0) ? rand_full()
              : longint'($urandom_range(0, 8000)) - 4000;
         y1 = ($urandom_range(0, 3) == 0) ? rand_full()
              : longint'($urandom_range(0, 8000)) - 4000;
         p.first_x  = x1[23:0];
         p.first_y  = y1[23:0];
         p.second_x = 24'(near_coord(x1, longint'($urandom_range(0, 2 * reach)) - reach));
         p.second_y = 24'(near_coord(y1, longint'($urandom_range(0, 2 * reach)) - reach));
         if (mode < 4) begin
            p.first_vx = 24'($urandom);  p.first_vy = 24'($urandom);
            p.second_vx = 24'($urandom); p.second_vy = 24'($urandom);
         end else begin
            p.first_vx  = 24'(longint'($urandom_range(0, 4000)) - 2000);
            p.first_vy  = 24'(longint'($urandom_range(0, 4000)) - 2000);
            p.second_vx = 24'(longint'($urandom_range(0, 4000)) - 2000);
            p.second_vy = 24'(longint'($urandom_range(0, 4000)) - 2000);
         end
         p.first_radius  = r1[15:0];
         p.second_radius = r2[15:0];
         if (mode == 9) begin
            // Coincident centres with random velocities.
            p.second_x = p.first_x;
            p.second_y = p.first_y;
         end
      end
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      // Coincident centres, touching.
      send_pair(make_pair(100, 200, 50, -50, 256, 100, 200, -50, 50, 256));
      // Coincident centres with zero radii: no touch.
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Distance exactly equal to the radius sum: not touching.
      send_pair(make_pair(0, 0, 10, 0, 256, 512, 0, -10, 0, 256));
      // One unit inside: touching and closing head-on.
      send_pair(make_pair(0, 0, 300, 0, 256, 511, 0, -300, 0, 256));
      // Touching but separating: push only.
      send_pair(make_pair(0, 0, -300, 0, 256, 400, 0, 300, 0, 256));
      // Diagonal touch, glancing velocities.
      send_pair(make_pair(-1000, -1000, 7, 3, 1000, -300, -400, -9, 11, 800));
      // Largest radii, far-apart centres at opposite corners.
      send_pair(make_pair(POS_MIN, POS_MIN, 0, 0, 65535, POS_MAX, POS_MAX, 0, 0, 65535));
      // Largest radii, near centres: huge push that saturates at the edges.
      send_pair(make_pair(POS_MAX - 5, POS_MIN + 5, 0, 0, 65535, POS_MAX, POS_MIN, 0, 0,
                          65535));
      send_pair(make_pair(POS_MIN, 0, 0, 0, 65535, POS_MIN + 3, 2, 0, 0, 65535));
      // Extreme velocities closing: impulse saturates.
      send_pair(make_pair(0, 0, POS_MAX, POS_MAX, 2000, 100, 100, POS_MIN, POS_MIN, 2000));
      send_pair(make_pair(0, 0, POS_MIN, 0, 2000, -100, 0, POS_MAX, 0, 2000));
      // Equal velocities: zero closing rate still takes the impulse path.
      send_pair(make_pair(0, 0, 77, 77, 500, 300, 0, 77, 77, 500));
      // Vertical touch, one radius zero.
      send_pair(make_pair(5, -600, 0, 900, 0, 5, 0, 0, -900, 700));
      // Far apart, all-ones style values pass through.
      send_pair(make_pair(-1, -1, -1, -1, 65535, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 0));
   endtask

   task automatic test_random_stream(int count, bit gaps, bit stalls);
      sender_gaps     = gaps;
      receiver_stalls = stalls;
      burst_left      = 0;
      repeat (count) send_pair(random_pair());
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Stall the receiver long enough that the pipe backs up onto the input.
   task automatic test_backpressure();
      sender_gaps    = 1'b0;
      holdoff_cycles = 300;
      repeat (150) send_pair(random_pair());
      drain_all();
      // Pause the sender until everything is back, then restart.
      repeat (60) send_pair(random_pair());
      sender_gaps = 1'b1;
   endtask

   task automatic test_bounce_settings();
      logic [8:0] coefs[4];
      coefs = '{9'd0, 9'd256, 9'd511, 9'd128};
      foreach (coefs[i]) begin
         write_bounce(coefs[i]);
         test_directed_cases();
         test_random_stream(280, 1'b1, 1'b1);
      end
      write_bounce(RESTITUTION_RESET);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      bounce_coef     = RESTITUTION_RESET;
      mismatch_count  = 0;
      pairs_sent      = 0;
      pairs_checked   = 0;
      hits_seen       = 0;
      cycle_count     = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      burst_left      = 0;
      holdoff_cycles  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_stream(300, 1'b0, 1'b0);
      test_random_stream(300, 1'b1, 1'b1);
      test_backpressure();
      test_bounce_settings();

      drain_all();
      $display("Covered %0d pairs (%0d resolved collisions) over five bounce settings,",
               pairs_checked, hits_seen);
      $display("with sender bursts, receiver stalls and a full-pipe hold-off.");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatching results", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### circle_pair_collision_response_core.f
+incdir+design
design/cpcr_pkg.sv
design/cpcr_sqrt.sv
design/cpcr_div.sv
design/circle_pair_collision_response_core.sv
sim/tb_circle_pair_collision_response_core.sv
